[rtl/core/keypad_pin_lock_controller_assert.svh]
// Assertion macros for the keypad PIN lock controller.
// Both expect a clock named clock and a synchronous reset named reset in the module.
`ifndef KEYPAD_PIN_LOCK_CONTROLLER_ASSERT_SVH
`define KEYPAD_PIN_LOCK_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define KPLC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("keypad lock assertion failed");

`define KPLC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keypad lock assertion failed");

`else

`define KPLC_ASSERT(lbl, prop)

`define KPLC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/core/kplc_pkg.sv]
`default_nettype none

package kplc_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_OPEN    = 2'd1,
      MODE_BLOCKED = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_DIGIT,
      ACT_ERASE,
      ACT_CLEAR,
      ACT_CHECK,
      ACT_OPEN,
      ACT_CLOSE,
      ACT_TICK,
      ACT_EXPIRE
   } action_type;

   localparam logic [1:0] CMD_KEY    = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_ROPEN  = 2'd2;
   localparam logic [1:0] CMD_RCLOSE = 2'd3;

   localparam logic [3:0] KEY_MAX_DIGIT = 4'd9;
   localparam logic [3:0] KEY_C    = 4'd12;
   localparam logic [3:0] KEY_D    = 4'd13;
   localparam logic [3:0] KEY_STAR = 4'd14;
   localparam logic [3:0] KEY_HASH = 4'd15;

   localparam logic [1:0] CSR_PIN_CODE      = 2'd0;
   localparam logic [1:0] CSR_MAX_ATTEMPTS  = 2'd1;
   localparam logic [1:0] CSR_OPEN_SECONDS  = 2'd2;
   localparam logic [1:0] CSR_BLOCK_SECONDS = 2'd3;

   localparam logic [15:0] PIN_CODE_RESET      = 16'h5555;
   localparam logic [3:0]  MAX_ATTEMPTS_RESET  = 4'd3;
   localparam logic [7:0]  OPEN_SECONDS_RESET  = 8'd5;
   localparam logic [7:0]  BLOCK_SECONDS_RESET = 8'd30;

   localparam logic [1:0] SERVO_NONE    = 2'd0;
   localparam logic [1:0] SERVO_UNLATCH = 2'd1;
   localparam logic [1:0] SERVO_LATCH   = 2'd2;

   localparam logic [1:0] LED_KEEP  = 2'd0;
   localparam logic [1:0] LED_OFF   = 2'd1;
   localparam logic [1:0] LED_GREEN = 2'd2;
   localparam logic [1:0] LED_RED   = 2'd3;

   localparam logic [1:0] BEEPS_NONE   = 2'd0;
   localparam logic [1:0] BEEPS_OPEN   = 2'd2;
   localparam logic [1:0] BEEPS_DENIED = 2'd3;

   localparam logic [2:0] DISP_NONE    = 3'd0;
   localparam logic [2:0] DISP_PROMPT  = 3'd1;
   localparam logic [2:0] DISP_WELCOME = 3'd2;
   localparam logic [2:0] DISP_WRONG   = 3'd3;
   localparam logic [2:0] DISP_BLOCKED = 3'd4;

   typedef struct packed {
      logic [15:0] pin_code;
      logic [3:0]  max_attempts;
      logic [7:0]  open_seconds;
      logic [7:0]  block_seconds;
   } cfg_type;

   typedef struct packed {
      logic [1:0] lock_mode;
      logic [2:0] digits_entered;
      logic [3:0] attempts_left;
      logic [1:0] servo_move;
      logic [1:0] led_mode;
      logic       key_click;
      logic [1:0] alert_beeps;
      logic       long_ring;
      logic [2:0] display_code;
   } result_type;

endpackage

`default_nettype wire

[rtl/core/kplc_csr.sv]
`default_nettype none

module kplc_csr
   import kplc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIN_CODE:      cfg_in.pin_code      = csr_data;
            CSR_MAX_ATTEMPTS:  cfg_in.max_attempts  = csr_data[3:0];
            CSR_OPEN_SECONDS:  cfg_in.open_seconds  = csr_data[7:0];
            CSR_BLOCK_SECONDS: cfg_in.block_seconds = csr_data[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_code      <= PIN_CODE_RESET;
         cfg_ff.max_attempts  <= MAX_ATTEMPTS_RESET;
         cfg_ff.open_seconds  <= OPEN_SECONDS_RESET;
         cfg_ff.block_seconds <= BLOCK_SECONDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/kplc_engine.sv]
`default_nettype none
`include "keypad_pin_lock_controller_assert.svh"

module kplc_engine
   import kplc_pkg::*;
#(
   parameter int PIN_LENGTH = 4
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic [1:0] command,
   input  wire logic [3:0] key_code,
   input  cfg_type         cfg,
   output result_type      result
);

   localparam int CW = $clog2(PIN_LENGTH + 1);

   mode_type      mode_ff, mode_in;
   logic [3:0]    entry_ff [PIN_LENGTH];
   logic [3:0]    entry_in [PIN_LENGTH];
   logic [3:0]    cand     [PIN_LENGTH];
   logic [CW-1:0] count_ff, count_in;
   logic [3:0]    failed_ff, failed_in;
   logic [7:0]    timer_ff, timer_in;

   action_type    action;
   logic [7:0]    timer_dec;
   logic [31:0]   pin_ext;
   logic          match;
   logic          do_check;
   logic          opened;
   logic          denied;
   logic [3:0]    failed_inc;
   logic          blocked_now;
   logic [7:0]    count_wide;
   logic          blocked_key;

   logic [1:0]    servo;
   logic [1:0]    led;
   logic          click;
   logic [1:0]    beeps;
   logic          ring;
   logic [2:0]    disp;

   assign timer_dec = timer_ff - 8'd1;
   assign pin_ext   = {16'd0, cfg.pin_code};

   always_comb begin
      action = ACT_NONE;
      case (command)
         CMD_KEY: begin
            if (mode_ff == MODE_OPEN) begin
               if (key_code == KEY_STAR) action = ACT_CLOSE;
            end else if (mode_ff == MODE_IDLE) begin
               if (key_code <= KEY_MAX_DIGIT) begin
                  if (count_ff < CW'(PIN_LENGTH)) action = ACT_DIGIT;
               end else if (key_code inside {KEY_HASH, KEY_D}) begin
                  if (count_ff == CW'(PIN_LENGTH)) action = ACT_CHECK;
               end else if (key_code == KEY_STAR) begin
                  if (count_ff != '0) action = ACT_ERASE;
               end else if (key_code == KEY_C) begin
                  action = ACT_CLEAR;
               end
            end
         end
         CMD_TICK: begin
            if (timer_ff != 8'd0) begin
               if (timer_dec == 8'd0 && mode_ff == MODE_OPEN) action = ACT_CLOSE;
               else if (timer_dec == 8'd0 && mode_ff == MODE_BLOCKED) action = ACT_EXPIRE;
               else action = ACT_TICK;
            end
         end
         CMD_ROPEN: begin
            if (mode_ff != MODE_BLOCKED) action = ACT_OPEN;
         end
         CMD_RCLOSE: begin
            if (mode_ff == MODE_OPEN) action = ACT_CLOSE;
         end
         default: action = ACT_NONE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < PIN_LENGTH; i++) begin
         cand[i] = entry_ff[i];
         if (action == ACT_DIGIT && CW'(i) == count_ff) cand[i] = key_code;
      end
      match = 1'b1;
      for (int i = 0; i < PIN_LENGTH; i++) begin
         if (cand[i] != pin_ext[4*i +: 4]) match = 1'b0;
      end
   end

   assign do_check    = (action == ACT_CHECK) ||
                        (action == ACT_DIGIT && count_ff == CW'(PIN_LENGTH - 1));
   assign opened      = (action == ACT_OPEN) || (do_check && match);
   assign denied      = do_check && !match;
   assign failed_inc  = (failed_ff == 4'hF) ? failed_ff : failed_ff + 4'd1;
   assign blocked_now = denied && (failed_inc >= cfg.max_attempts);

   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      failed_in = failed_ff;
      timer_in  = timer_ff;
      for (int i = 0; i < PIN_LENGTH; i++) entry_in[i] = entry_ff[i];

      case (action)
         ACT_DIGIT: begin
            for (int i = 0; i < PIN_LENGTH; i++) entry_in[i] = cand[i];
            count_in = count_ff + CW'(1);
         end
         ACT_ERASE: begin
            for (int i = 0; i < PIN_LENGTH; i++) begin
               if (CW'(i + 1) == count_ff) entry_in[i] = 4'd0;
            end
            count_in = count_ff - CW'(1);
         end
         ACT_CLEAR: begin
            for (int i = 0; i < PIN_LENGTH; i++) entry_in[i] = 4'd0;
            count_in = '0;
         end
         ACT_CLOSE, ACT_EXPIRE: begin
            mode_in  = MODE_IDLE;
            timer_in = 8'd0;
            for (int i = 0; i < PIN_LENGTH; i++) entry_in[i] = 4'd0;
            count_in = '0;
            if (action == ACT_EXPIRE) failed_in = 4'd0;
         end
         ACT_TICK: timer_in = timer_dec;
         default: mode_in = mode_ff;
      endcase

      if (opened) begin
         mode_in   = MODE_OPEN;
         timer_in  = cfg.open_seconds;
         failed_in = 4'd0;
      end else if (denied) begin
         failed_in = failed_inc;
         for (int i = 0; i < PIN_LENGTH; i++) entry_in[i] = 4'd0;
         count_in = '0;
         if (blocked_now) begin
            mode_in  = MODE_BLOCKED;
            timer_in = cfg.block_seconds;
         end else begin
            mode_in = MODE_IDLE;
         end
      end
   end

   always_comb begin
      servo = SERVO_NONE;
      led   = LED_KEEP;
      click = 1'b0;
      beeps = BEEPS_NONE;
      ring  = 1'b0;
      disp  = DISP_NONE;
      case (action)
         ACT_DIGIT, ACT_ERASE, ACT_CLEAR: begin
            click = 1'b1;
            disp  = DISP_PROMPT;
         end
         ACT_CLOSE, ACT_EXPIRE: begin
            servo = SERVO_LATCH;
            led   = LED_OFF;
            disp  = DISP_PROMPT;
         end
         default: servo = SERVO_NONE;
      endcase
      if (opened) begin
         servo = SERVO_UNLATCH;
         led   = LED_GREEN;
         beeps = BEEPS_OPEN;
         disp  = DISP_WELCOME;
      end else if (denied) begin
         led   = LED_RED;
         beeps = BEEPS_DENIED;
         ring  = blocked_now;
         disp  = blocked_now ? DISP_BLOCKED : DISP_WRONG;
      end
   end

   assign count_wide = 8'(count_in);

   always_comb begin
      result.lock_mode      = mode_in;
      result.digits_entered = count_wide[2:0];
      result.attempts_left  = (failed_in >= cfg.max_attempts) ? 4'd0
                                                               : cfg.max_attempts - failed_in;
      result.servo_move     = servo;
      result.led_mode       = led;
      result.key_click      = click;
      result.alert_beeps    = beeps;
      result.long_ring      = ring;
      result.display_code   = disp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         count_ff  <= '0;
         failed_ff <= 4'd0;
         timer_ff  <= 8'd0;
         for (int i = 0; i < PIN_LENGTH; i++) entry_ff[i] <= 4'd0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         failed_ff <= failed_in;
         timer_ff  <= timer_in;
         for (int i = 0; i < PIN_LENGTH; i++) entry_ff[i] <= entry_in[i];
      end
   end

   assign blocked_key = step_en && mode_ff == MODE_BLOCKED && command == CMD_KEY;

   `KPLC_ASSERT(a_count_bound, count_ff <= CW'(PIN_LENGTH))
   `KPLC_ASSERT(a_blocked_empty, mode_ff != MODE_BLOCKED || count_ff == '0)
   `KPLC_ASSERT_NEXT(a_blocked_keys, blocked_key, mode_ff == MODE_BLOCKED)
   `KPLC_ASSERT_NEXT(a_open_resets, step_en && opened, failed_ff == 4'd0 && mode_ff == MODE_OPEN)

endmodule

`default_nettype wire

[rtl/core/keypad_pin_lock_controller.sv]
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   command, key_code
// rsp_      out        rsp_valid/rsp_stall   lock mode, entry count, attempts, actuator codes
// csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// The result is offered once its request transaction has passed the input register and
// then the result register; the lock state is written together with the result.
// One transaction is accepted in every cycle while the result side is not stalled.
// Reset is synchronous and restores the configuration registers to their defaults and the lock to idle.
// A stalled result holds the input register, which then stalls the request side.
`default_nettype none

module keypad_pin_lock_controller
   import kplc_pkg::*;
#(
   parameter int PIN_LENGTH = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [3:0]  req_key_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_lock_mode,
   output logic [2:0]       rsp_digits_entered,
   output logic [3:0]       rsp_attempts_left,
   output logic [1:0]       rsp_servo_move,
   output logic [1:0]       rsp_led_mode,
   output logic             rsp_key_click,
   output logic [1:0]       rsp_alert_beeps,
   output logic             rsp_long_ring,
   output logic [2:0]       rsp_display_code,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_ff, rsp_in;

   logic       in_valid_ff, in_valid_in;
   logic [1:0] command_ff, command_in;
   logic [3:0] key_ff, key_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      command_in  = command_ff;
      key_in      = key_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            command_in = req_command;
            key_in     = req_key_code;
         end
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_in       = advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      command_ff <= command_in;
      key_ff     <= key_in;
      rsp_ff     <= rsp_in;
   end

   kplc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kplc_engine #(
      .PIN_LENGTH (PIN_LENGTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .command  (command_ff),
      .key_code (key_ff),
      .cfg      (cfg),
      .result   (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_lock_mode      = rsp_ff.lock_mode;
   assign rsp_digits_entered = rsp_ff.digits_entered;
   assign rsp_attempts_left  = rsp_ff.attempts_left;
   assign rsp_servo_move     = rsp_ff.servo_move;
   assign rsp_led_mode       = rsp_ff.led_mode;
   assign rsp_key_click      = rsp_ff.key_click;
   assign rsp_alert_beeps    = rsp_ff.alert_beeps;
   assign rsp_long_ring      = rsp_ff.long_ring;
   assign rsp_display_code   = rsp_ff.display_code;

endmodule

`default_nettype wire
